// ===== hw/rtl/sbfsd_pkg.sv =====
// Shared types and constants for the SBUS frame sync decoder.
// Holds the beat structs, register indexes and phase codes.
// No dependencies.
package sbfsd_pkg;

    localparam int unsigned PHASE_W = 6;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned CFG_W   = 16;

    localparam logic [PHASE_W-1:0] PH_HUNT     = 6'd40;
    localparam logic [PHASE_W-1:0] PH_SKIP_LOW = 6'd30;
    localparam logic [3:0]         SKIP_WRAP   = 4'd10;
    localparam int unsigned        FS_BIT      = 3;

    localparam logic [7:0]       HEADER_RST = 8'h0F;
    localparam logic [7:0]       FOOTER_RST = 8'h00;
    localparam logic [3:0]       REQ_RST    = 4'd5;
    localparam logic [CNT_W-1:0] FS_MS_RST  = 16'd100;

    typedef enum logic [1:0] {
        REG_HEADER   = 2'd0,
        REG_FOOTER   = 2'd1,
        REG_REQ_SYNC = 2'd2,
        REG_FS_MS    = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_type_t;

    typedef enum logic {
        KIND_STATUS  = 1'b0,
        KIND_PAYLOAD = 1'b1
    } kind_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_beat_t;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       byte_value;
        logic             last;
        logic             failsafe;
        logic             out_of_sync;
        logic [CNT_W-1:0] failsafe_events;
        logic [CNT_W-1:0] frames_seen;
        logic [CNT_W-1:0] resync_events;
    } out_beat_t;

endpackage

// ===== hw/rtl/sbus_frame_sync_decoder_top.sv =====
// SBUS frame sync decoder, top level.
// Depends on sbfsd_pkg. Frame body held in a one-port-write, registered-read buffer.
//
// Usage:
//   s_ channel: one beat per received byte (req_type 0) or per 1 ms tick (req_type 1).
//   m_ channel: for each input beat, the released payload bytes (if that byte
//   confirmed a frame with enough good frames in a row) followed by one status
//   beat with last set. Status fields hold the values after that input.
//   cfg_we/cfg_index/cfg_wdata write header, footer, required sync count and
//   failsafe timeout; write only while the block is idle.
// Sequencing:
//   The input beat updates all scalar state in the accept cycle. A status-only
//   input then moves to the status state, which loads its beat once the output is free.
//   A releasing input primes the frame buffer read, then streams
//   FRAME_BYTES-2 payload beats at one per cycle from the buffer read port while
//   m_ready does not stall, then the status beat.
//   A new input is accepted while the last result still waits in the output
//   register.
// Reset: aresetn (synchronous, active low) restores register defaults, hunts
//   for a footer, clears counters and sets the held failsafe flag.
// Stall: while m_ready is low the output register holds and emission pauses.
module sbus_frame_sync_decoder_top #(
    parameter int unsigned FRAME_BYTES = 25
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sbfsd_pkg::in_beat_t            s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sbfsd_pkg::out_beat_t           m_data,
    input  logic                           cfg_we,
    input  sbfsd_pkg::cfg_idx_t            cfg_index,
    input  logic [sbfsd_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int unsigned AW = $clog2(FRAME_BYTES);
    localparam int unsigned PW = sbfsd_pkg::PHASE_W;
    localparam int unsigned CW = sbfsd_pkg::CNT_W;
    localparam logic [PW-1:0] PH_LAST_BODY = PW'(FRAME_BYTES - 2);
    localparam logic [PW-1:0] PH_FOOTER    = PW'(FRAME_BYTES - 1);
    localparam logic [PW-1:0] PH_NEXT_HDR  = PW'(FRAME_BYTES);
    localparam logic [AW-1:0] IDX_LAST     = AW'(FRAME_BYTES - 2);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PRIME = 4'b0010,
        ST_PAY   = 4'b0100,
        ST_STAT  = 4'b1000
    } state_t;

    // configuration
    logic [7:0]    header_reg;
    logic [7:0]    footer_reg;
    logic [3:0]    req_sync_reg;
    logic [CW-1:0] fs_ms_reg;

    // scalar state
    state_t        state_reg, state_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic [3:0]    sync_reg, sync_next;
    logic [3:0]    skip_reg, skip_next;
    logic [CW-1:0] elapsed_reg, elapsed_next;
    logic          held_reg, held_next;
    logic          fs_reg, fs_next;
    logic [CW-1:0] fs_cnt_reg, fs_cnt_next;
    logic [CW-1:0] frame_cnt_reg, frame_cnt_next;
    logic [CW-1:0] resync_cnt_reg, resync_cnt_next;
    logic          fsbit_reg, fsbit_next;
    logic [AW-1:0] idx_reg, idx_next;

    // frame buffer
    logic [7:0]    buf_mem [FRAME_BYTES];
    logic          buf_we;
    logic [AW-1:0] buf_waddr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data_reg;

    // output stage
    logic                 m_valid_reg;
    sbfsd_pkg::out_beat_t m_data_reg, m_data_next;
    logic                 slot_free;
    logic                 load;

    logic          accept;
    logic          release_hit;
    logic          retry;
    logic          fs_res;
    logic [CW-1:0] el;
    logic [3:0]    skip_inc;
    logic [3:0]    skip_rs;
    logic [PW-1:0] ph_rs;
    logic [7:0]    b;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign b         = s_data.rx_byte;
    assign buf_waddr = phase_reg[AW-1:0];

    assign skip_inc = skip_reg + 4'd1;
    assign skip_rs  = (skip_inc > sbfsd_pkg::SKIP_WRAP) ? 4'd0 : skip_inc;
    assign ph_rs    = sbfsd_pkg::PH_HUNT - {2'b00, skip_rs};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg   <= sbfsd_pkg::HEADER_RST;
            footer_reg   <= sbfsd_pkg::FOOTER_RST;
            req_sync_reg <= sbfsd_pkg::REQ_RST;
            fs_ms_reg    <= sbfsd_pkg::FS_MS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sbfsd_pkg::REG_HEADER:   header_reg   <= cfg_wdata[7:0];
                sbfsd_pkg::REG_FOOTER:   footer_reg   <= cfg_wdata[7:0];
                sbfsd_pkg::REG_REQ_SYNC: req_sync_reg <= cfg_wdata[3:0];
                sbfsd_pkg::REG_FS_MS:    fs_ms_reg    <= cfg_wdata;
            endcase
        end
    end

    // per-input state update
    always_comb begin
        phase_next      = phase_reg;
        sync_next       = sync_reg;
        skip_next       = skip_reg;
        held_next       = held_reg;
        fs_next         = fs_reg;
        fs_cnt_next     = fs_cnt_reg;
        frame_cnt_next  = frame_cnt_reg;
        resync_cnt_next = resync_cnt_reg;
        fsbit_next      = fsbit_reg;
        elapsed_next    = elapsed_reg;
        release_hit     = 1'b0;
        buf_we          = 1'b0;
        retry           = 1'b0;
        fs_res          = 1'b0;
        el              = elapsed_reg;
        if (accept) begin
            if (s_data.req_type == sbfsd_pkg::REQ_TICK) begin
                if (elapsed_reg != '1) begin
                    el = elapsed_reg + CW'(1);
                end
            end else begin
                priority if (phase_reg == sbfsd_pkg::PH_HUNT) begin
                    if (b == footer_reg) begin
                        phase_next = '0;
                        sync_next  = 4'd0;
                    end
                end else if (phase_reg >= sbfsd_pkg::PH_SKIP_LOW) begin
                    phase_next = phase_reg + PW'(1);
                end else if (phase_reg == '0) begin
                    if (b == header_reg) begin
                        phase_next = PW'(1);
                    end else begin
                        retry = 1'b1;
                    end
                end else if (phase_reg == PH_FOOTER) begin
                    if (b == footer_reg) begin
                        phase_next = PH_NEXT_HDR;
                    end else begin
                        retry = 1'b1;
                    end
                end else if (phase_reg == PH_NEXT_HDR) begin
                    if (b == header_reg) begin
                        frame_cnt_next = frame_cnt_reg + CW'(1);
                        if (sync_reg == req_sync_reg) begin
                            held_next   = fsbit_reg;
                            el          = '0;
                            release_hit = 1'b1;
                        end else begin
                            sync_next = sync_reg + 4'd1;
                        end
                        phase_next = PW'(1);
                    end else begin
                        skip_next       = skip_rs;
                        phase_next      = ph_rs;
                        resync_cnt_next = resync_cnt_reg + CW'(1);
                    end
                end else begin
                    buf_we = 1'b1;
                    if (phase_reg == PH_LAST_BODY) begin
                        fsbit_next = b[sbfsd_pkg::FS_BIT];
                    end
                    phase_next = phase_reg + PW'(1);
                end
                // header/footer mismatch: resync; if that returns to hunt, re-examine the byte as a footer
                if (retry) begin
                    skip_next       = skip_rs;
                    resync_cnt_next = resync_cnt_reg + CW'(1);
                    if (ph_rs == sbfsd_pkg::PH_HUNT) begin
                        if (b == footer_reg) begin
                            phase_next = '0;
                            sync_next  = 4'd0;
                        end else begin
                            phase_next = sbfsd_pkg::PH_HUNT;
                        end
                    end else begin
                        phase_next = ph_rs + PW'(1);
                    end
                end
            end
            fs_res = held_next;
            if (el >= fs_ms_reg) begin
                el     = fs_ms_reg;
                fs_res = 1'b1;
            end
            if (!fs_reg && fs_res) begin
                fs_cnt_next = fs_cnt_reg + CW'(1);
            end
            fs_next      = fs_res;
            elapsed_next = el;
        end
    end

    // emission sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        load       = 1'b0;
        rd_addr    = idx_reg;
        m_data_next.kind            = sbfsd_pkg::KIND_STATUS;
        m_data_next.byte_index      = '0;
        m_data_next.byte_value      = '0;
        m_data_next.last            = 1'b1;
        m_data_next.failsafe        = fs_reg;
        m_data_next.out_of_sync     = (sync_reg < req_sync_reg) || held_reg;
        m_data_next.failsafe_events = fs_cnt_reg;
        m_data_next.frames_seen     = frame_cnt_reg;
        m_data_next.resync_events   = resync_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (release_hit) begin
                        idx_next   = AW'(1);
                        state_next = ST_PRIME;
                    end else begin
                        state_next = ST_STAT;
                    end
                end
            end
            ST_PRIME: begin
                state_next = ST_PAY;
            end
            ST_PAY: begin
                m_data_next.kind       = sbfsd_pkg::KIND_PAYLOAD;
                m_data_next.byte_index = sbfsd_pkg::IDX_W'(idx_reg);
                m_data_next.byte_value = rd_data_reg;
                m_data_next.last       = 1'b0;
                if (slot_free) begin
                    load     = 1'b1;
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                    if (idx_reg == IDX_LAST) begin
                        state_next = ST_STAT;
                    end
                end
            end
            ST_STAT: begin
                if (slot_free) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[buf_waddr] <= b;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= sbfsd_pkg::PH_HUNT;
            sync_reg       <= 4'd0;
            skip_reg       <= 4'd0;
            elapsed_reg    <= '0;
            held_reg       <= 1'b1;
            fs_reg         <= 1'b0;
            fs_cnt_reg     <= '0;
            frame_cnt_reg  <= '0;
            resync_cnt_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            sync_reg       <= sync_next;
            skip_reg       <= skip_next;
            elapsed_reg    <= elapsed_next;
            held_reg       <= held_next;
            fs_reg         <= fs_next;
            fs_cnt_reg     <= fs_cnt_next;
            frame_cnt_reg  <= frame_cnt_next;
            resync_cnt_reg <= resync_cnt_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fsbit_reg <= fsbit_next;
        idx_reg   <= idx_next;
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= sbfsd_pkg::PH_HUNT)
        else $error("phase out of range");

    a_skip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg <= sbfsd_pkg::SKIP_WRAP)
        else $error("skip step out of range");

    a_pay_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAY) |-> (idx_reg != '0 && idx_reg <= IDX_LAST))
        else $error("payload index out of range");

    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.last == (m_data_reg.kind == sbfsd_pkg::KIND_STATUS)))
        else $error("last flag does not match beat kind");

    a_release_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && release_hit) |=> (state_reg == ST_PRIME))
        else $error("released frame not streamed");

endmodule
